>>> rtl/crdp_pkg.sv
// ----------------------------------------------------------------------------
// crdp_pkg
// Shared codes and field widths for the sparse row dot-product engine.
// ----------------------------------------------------------------------------
package crdp_pkg;

	localparam int CMD_W  = 2;
	localparam int IDX_W  = 10;
	localparam int VAL_W  = 32;
	localparam int THR_W  = 31;
	localparam int MODE_W = 2;
	localparam int STAT_W = 2;
	localparam int SUM_W  = 64;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLOSE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_VECTOR = 2'd2;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

	localparam logic [MODE_W-1:0] MODE_ALL   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOWER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_UPPER = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STAT_W-1:0] ST_SUM     = 2'd3;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

>>> rtl/crdp_if.sv
// ----------------------------------------------------------------------------
// crdp_if
// Valid/ready channels of the sparse row dot-product engine.
// ----------------------------------------------------------------------------
interface crdp_req_if;
	import crdp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [IDX_W-1:0]         row_number;
	logic [IDX_W-1:0]         column_number;
	logic signed [VAL_W-1:0]  number_in;
	logic [MODE_W-1:0]        product_mode;
	modport source (output valid, command, row_number, column_number, number_in,
		product_mode, input ready);
	modport sink (input valid, command, row_number, column_number, number_in,
		product_mode, output ready);
endinterface

interface crdp_rsp_if;
	import crdp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [SUM_W-1:0]  row_sum;
	modport source (output valid, status, row_sum, input ready);
	modport sink (input valid, status, row_sum, output ready);
endinterface

interface crdp_cfg_if;
	import crdp_pkg::*;
	logic             valid;
	logic             ready;
	logic [THR_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/crdp_ram.sv
// ----------------------------------------------------------------------------
// crdp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module crdp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/csr_row_dot_product_engine.sv
// ----------------------------------------------------------------------------
// csr_row_dot_product_engine
// Compressed-sparse-row matrix store with saturating row-times-vector sums.
//
//   channel | dir | beat contents
//   --------+-----+-----------------------------------------------------------
//   cfg     | in  | data: drop threshold, unsigned Q15.16
//   req     | in  | command, row_number, column_number, number_in, product_mode
//   rsp     | out | status, row_sum (signed Q32.32)
//
// Append, close and vector writes are done in the cycle they are accepted. A
// query reads both row pointers, then walks the stored entries of the row
// through the entry pipeline and drains it, then loads the output register;
// the walk is paced by the single read port of the entry memory.
// After reset every entry of the row pointer memory is cleared, with
// req.ready low. req.ready also stays low during a query and while a result
// waits in the output register.
// ----------------------------------------------------------------------------
module csr_row_dot_product_engine #(
	parameter int MATRIX_SIZE = 1024,
	parameter int MAX_ENTRIES = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	crdp_cfg_if.sink  cfg,
	crdp_req_if.sink  req,
	crdp_rsp_if.source rsp
);
	import crdp_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int EAW   = $clog2(MAX_ENTRIES);
	localparam int RAW   = $clog2(MATRIX_SIZE + 1);
	localparam int VAW   = $clog2(MATRIX_SIZE);
	localparam int CLR_W = $clog2(MATRIX_SIZE + 2);
	localparam int EW    = VAL_W + IDX_W;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_STOP  = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]              state_q;
	logic [CLR_W-1:0]        clr_q;
	logic [THR_W-1:0]        thr_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        row_q;
	logic [MODE_W-1:0]       mode_q;
	logic [CNT_W-1:0]        start_q, stop_q, ptr_q;
	logic signed [SUM_W-1:0] acc_q;
	logic                    out_valid_q;
	logic [STAT_W-1:0]       out_status_q;
	logic signed [SUM_W-1:0] out_sum_q;

	logic                    v_s1, v_s2, v_s3;
	logic                    sel_s2;
	logic signed [VAL_W-1:0] val_s2;
	logic signed [SUM_W-1:0] prod_s3;

	logic accept, out_free, issue, out_load;
	logic [31:0] row_ext, col_ext, row1_ext, s1_col_ext;
	logic signed [VAL_W:0] num_ext;
	logic [VAL_W:0] mag;
	logic row_ok, col_ok, query_ok;

	logic           re_we;
	logic [RAW-1:0] re_waddr, re_raddr;
	logic [CNT_W-1:0] re_wdata, re_rdata;
	logic           en_we;
	logic [EW-1:0]  en_rdata;
	logic           vec_we;
	logic [VAW-1:0] vec_raddr;
	logic [VAL_W-1:0] vec_rdata;

	logic [IDX_W-1:0]        s1_col;
	logic                    s1_sel;
	logic signed [SUM_W-1:0] sum_nx;
	logic                    ovf;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign row_ext  = 32'(req.row_number);
	assign col_ext  = 32'(req.column_number);
	assign row1_ext = 32'(row_q) + 32'd1;
	assign row_ok   = row_ext < 32'(MATRIX_SIZE);
	assign col_ok   = col_ext < 32'(MATRIX_SIZE);
	assign query_ok = row_ok && (req.product_mode != MODE_NONE);

	// Every beat except a query that walks a row answers right away.
	assign out_load = (accept && !(req.command == CMD_QUERY && query_ok))
		|| (state_q == S_DONE && out_free);

	assign num_ext = {req.number_in[VAL_W-1], req.number_in};
	assign mag     = req.number_in[VAL_W-1] ? 33'(-num_ext) : 33'(num_ext);

	// Row pointer memory: cleared after reset, written by close commands.
	always_comb begin
		re_we    = 1'b0;
		re_waddr = RAW'(32'(clr_q));
		re_wdata = '0;
		if (state_q == S_CLEAR) begin
			re_we = 1'b1;
		end else if (accept && req.command == CMD_CLOSE && row_ok) begin
			re_we    = 1'b1;
			re_waddr = RAW'(row_ext + 32'd1);
			re_wdata = count_q;
		end
		re_raddr = (state_q == S_IDLE) ? RAW'(row_ext) : RAW'(row1_ext);
	end

	crdp_ram #(.WIDTH(CNT_W), .DEPTH(MATRIX_SIZE + 1)) u_row_ends (
		.clk(clk), .we(re_we), .waddr(re_waddr), .wdata(re_wdata),
		.raddr(re_raddr), .rdata(re_rdata)
	);

	assign en_we = accept && req.command == CMD_APPEND
		&& !(mag < 33'(thr_q)) && (count_q != CNT_W'(MAX_ENTRIES));
	assign issue = (state_q == S_WALK) && (ptr_q < stop_q);

	crdp_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entries (
		.clk(clk), .we(en_we), .waddr(count_q[EAW-1:0]),
		.wdata({req.number_in, req.column_number}),
		.raddr(ptr_q[EAW-1:0]), .rdata(en_rdata)
	);

	// Stage 1: entry word is back; filter its column and fetch the vector element.
	assign s1_col     = en_rdata[IDX_W-1:0];
	assign s1_col_ext = 32'(s1_col);
	always_comb begin
		s1_sel = s1_col_ext < 32'(MATRIX_SIZE);
		if (mode_q == MODE_LOWER && !(s1_col < row_q)) begin
			s1_sel = 1'b0;
		end
		if (mode_q == MODE_UPPER && !(s1_col > row_q)) begin
			s1_sel = 1'b0;
		end
	end
	assign vec_raddr = VAW'(s1_col_ext);
	assign vec_we    = accept && req.command == CMD_VECTOR && col_ok;

	crdp_ram #(.WIDTH(VAL_W), .DEPTH(MATRIX_SIZE)) u_vector (
		.clk(clk), .we(vec_we), .waddr(VAW'(col_ext)), .wdata(req.number_in),
		.raddr(vec_raddr), .rdata(vec_rdata)
	);

	assign sum_nx = acc_q + prod_s3;
	assign ovf    = (acc_q[SUM_W-1] == prod_s3[SUM_W-1]) && (sum_nx[SUM_W-1] != acc_q[SUM_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			thr_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
		end else begin
			if (cfg.valid) begin
				thr_q <= cfg.data;
			end
			if (en_we) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && sel_s2;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == 32'(MATRIX_SIZE)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && req.command == CMD_QUERY && query_ok) begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= S_STOP;
				S_STOP: begin
					stop_q  <= re_rdata;
					ptr_q   <= start_q;
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (issue) begin
						ptr_q <= ptr_q + 1'b1;
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			row_q        <= req.row_number;
			mode_q       <= req.product_mode;
			out_sum_q    <= '0;
			case (req.command)
				CMD_APPEND: begin
					if (mag < 33'(thr_q)) begin
						out_status_q <= ST_DROPPED;
					end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
						out_status_q <= ST_FULL;
					end else begin
						out_status_q <= ST_DONE;
					end
				end
				CMD_QUERY: out_status_q <= ST_SUM;
				default:   out_status_q <= ST_DONE;
			endcase
		end
		if (state_q == S_START) begin
			start_q <= re_rdata;
		end
		if (state_q == S_STOP) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= ovf ? (acc_q[SUM_W-1] ? SUM_MIN : SUM_MAX) : sum_nx;
		end
		if (state_q == S_DONE && out_free) begin
			out_sum_q <= acc_q;
		end
		sel_s2  <= s1_sel;
		val_s2  <= $signed(en_rdata[EW-1:IDX_W]);
		prod_s3 <= val_s2 * $signed(vec_rdata);
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.row_sum = out_sum_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond capacity");
	a_walk_only: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2 || v_s3) |-> state_q == S_WALK)
		else $error("entry pipeline busy outside a row walk");
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |=> out_valid_q)
		else $error("waiting result dropped");
`endif
endmodule
